/* design/pas_pkg.sv */
// Shared types and constants for the PUCT action selector.
// No dependencies; imported by every module of the block.
package pas_pkg;

   localparam int MAX_ACTIONS = 64;
   localparam int ACT_W       = $clog2(MAX_ACTIONS);
   localparam int CNT_W       = ACT_W + 1;
   localparam int VIS_W       = 24;
   localparam int SUM_W       = 40;
   localparam int TOT_W       = 30;
   localparam int ROOT_W      = 31;
   localparam int DIVD_W      = 40;
   localparam int DIVS_W      = 25;
   localparam int SCORE_W     = 42;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_LOAD   = 2'd1,
      KIND_BACKUP = 2'd2,
      KIND_SELECT = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_EXPLORE_GAIN = 2'd0,
      REG_ACTION_COUNT = 2'd1
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RMW,
      ST_SQRT,
      ST_FETCH,
      ST_ENTRY,
      ST_MUL,
      ST_QSTART,
      ST_QDIV,
      ST_EDIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             legal;
      logic [15:0]      prior;
      logic [VIS_W-1:0] visits;
      logic [SUM_W-1:0] win;
      logic [SUM_W-1:0] loss;
   } entry_type;

endpackage

/* design/pas_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pas_pkg for operand widths.
module pas_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pas_pkg::DIVD_W-1:0]  dividend,
   input  logic [pas_pkg::DIVS_W-1:0]  divisor,
   output logic                        done,
   output logic [pas_pkg::DIVD_W-1:0]  quotient
);
   import pas_pkg::*;

   localparam int STEP_W = $clog2(DIVD_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVD_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [DIVS_W-1:0]   rem_ff, rem_in;
   logic [DIVD_W-1:0]   quo_ff, quo_in;
   logic [DIVS_W-1:0]   dvs_ff, dvs_in;
   logic [DIVS_W:0]     rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff, quo_ff[DIVD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = DIVS_W'(rem_sh - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIVS_W-1:0];
            quo_in = {quo_ff[DIVD_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* design/puct_action_selector.sv */
// Top level of the PUCT action selector: statistics memory, square root,
// scoring sequencer and result register. Depends on pas_pkg and pas_div.
//
// Usage:
//   req_* carries one transaction: kind, action, legal, prior, win_value,
//   loss_value. It is taken at a clock edge with req_valid high and
//   req_stall low. Clear does not raise req_stall. Load and backup read,
//   then write the action's entry; an action at or beyond action_count is
//   dropped. Select produces one rsp_* transaction: rsp_choice and rsp_no_legal.
//   Select steps: the square root of the visit total (taken as one when the
//   total is zero), then per action in use a fetch; a legal action adds a
//   multiply and, on the shared divider, one division when unvisited or
//   two when visited; last the result is posted. The divisions dominate
//   the time a select takes.
//   req_stall stays high while a transaction is in work.
//   The result sits in an output register: while rsp_stall is high it holds,
//   and the block still takes clear, load and backup transactions; a
//   further select waits at its end until the register is free.
//   csr_* writes explore_gain (index 0) and action_count (index 1); it is
//   always ready. Reset restores gain 4096, count 64 and an empty node;
//   the entry valid bits make the memory read as zero, with no clear sweep.
module puct_action_selector (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_kind,
   input  logic [5:0]                req_action,
   input  logic                      req_legal,
   input  logic [15:0]               req_prior,
   input  logic [15:0]               req_win_value,
   input  logic [15:0]               req_loss_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [5:0]                rsp_choice,
   output logic                      rsp_no_legal,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [15:0]               csr_data
);
   import pas_pkg::*;

   localparam logic [VIS_W-1:0] VIS_MAX = '1;
   localparam logic [TOT_W-1:0] TOT_MAX = '1;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;
   localparam int SQ_STEPS = ROOT_W;
   localparam int SQ_CNT_W = $clog2(SQ_STEPS);
   localparam int RAD_W    = 2 * ROOT_W;
   localparam int REM_W    = ROOT_W + 3;

   // configuration
   logic [15:0]        gain_ff;
   logic [6:0]         count_ff;
   logic [CNT_W-1:0]   n_eff;

   // statistics memory with per-entry valid bits
   entry_type          mem [MAX_ACTIONS];
   logic [MAX_ACTIONS-1:0] vld_ff;
   entry_type          rd_entry_ff;
   logic               rd_vld_ff;
   entry_type          cur;
   logic [ACT_W-1:0]   rd_addr;
   logic               mem_we;
   entry_type          wr_entry;
   logic [TOT_W-1:0]   total_ff;

   // latched request
   kind_type           kind_ff;
   logic [ACT_W-1:0]   action_ff;
   logic               legal_ff;
   logic [15:0]        prior_ff;
   logic [15:0]        winv_ff;
   logic [15:0]        lossv_ff;

   // sequencer
   state_type          state_ff, state_in;
   logic               accept;
   logic               in_range;

   // square root
   logic [RAD_W-1:0]   rad_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [SQ_CNT_W-1:0] sq_cnt_ff;
   logic [REM_W-1:0]   rem_sh;
   logic [REM_W-1:0]   trial;

   // scoring
   logic [CNT_W-1:0]   idx_ff;
   logic               last_idx;
   logic [31:0]        gp_ff;
   logic [DIVD_W-1:0]  num_ff;
   logic [2*ROOT_W:0]  prod;
   logic [VIS_W-1:0]   v_ff;
   logic               neg_ff;
   logic [SUM_W-1:0]   mag_ff;
   logic [SUM_W:0]     diff;
   logic [SUM_W:0]     q_ff;
   logic [SUM_W:0]     q_new;
   logic [SCORE_W-1:0] score;
   logic [SCORE_W-1:0] best_ff;
   logic [ACT_W-1:0]   best_idx_ff;
   logic               found_ff;

   // shared divider
   logic               div_start;
   logic [DIVD_W-1:0]  div_dividend;
   logic [DIVS_W-1:0]  div_divisor;
   logic               div_done;
   logic [DIVD_W-1:0]  div_quo;

   // result register
   logic               rsp_valid_ff;
   logic [ACT_W-1:0]   rsp_best_ff;
   logic               rsp_none_ff;
   logic               rsp_free;

   pas_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign csr_ready = 1'b1;
   assign n_eff     = (count_ff > 7'(MAX_ACTIONS)) ? CNT_W'(MAX_ACTIONS)
                                                  : CNT_W'(count_ff);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign in_range  = {1'b0, req_action} < n_eff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign last_idx  = (idx_ff + 1'b1) >= n_eff;

   // an entry never written since the last clear reads as zero
   assign cur = rd_vld_ff ? rd_entry_ff : '0;

   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign prod   = (2*ROOT_W+1)'(gp_ff) * (2*ROOT_W+1)'(root_ff);
   assign diff   = {1'b0, cur.win} - {1'b0, cur.loss};
   assign q_new  = neg_ff ? (SUM_W+1)'(-{1'b0, div_quo}) : {1'b0, div_quo};
   assign score  = {q_ff[SUM_W], q_ff} + {2'b00, div_quo};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (kind_type'(req_kind))
                  KIND_CLEAR:  state_in = ST_IDLE;
                  KIND_LOAD,
                  KIND_BACKUP: state_in = in_range ? ST_RMW : ST_IDLE;
                  KIND_SELECT: state_in = ST_SQRT;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_RMW:    state_in = ST_IDLE;
         ST_SQRT: begin
            if (total_ff == '0 || sq_cnt_ff == SQ_CNT_W'(SQ_STEPS - 1))
               state_in = (n_eff == '0) ? ST_DONE : ST_FETCH;
         end
         ST_FETCH:  state_in = ST_ENTRY;
         ST_ENTRY: begin
            if (cur.legal)
               state_in = ST_MUL;
            else
               state_in = last_idx ? ST_DONE : ST_FETCH;
         end
         ST_MUL:    state_in = ST_QSTART;
         ST_QSTART: state_in = (v_ff == '0) ? ST_EDIV : ST_QDIV;
         ST_QDIV:   if (div_done) state_in = ST_EDIV;
         ST_EDIV: begin
            if (div_done) state_in = last_idx ? ST_DONE : ST_FETCH;
         end
         ST_DONE:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      mem_we       = 1'b0;
      wr_entry     = cur;
      rd_addr      = (state_ff == ST_IDLE) ? req_action : idx_ff[ACT_W-1:0];
      div_start    = 1'b0;
      div_dividend = {1'b0, mag_ff[SUM_W-1:1]} ;
      div_divisor  = {1'b0, v_ff};
      unique case (state_ff)
         ST_RMW: begin
            mem_we = 1'b1;
            if (kind_ff == KIND_LOAD) begin
               wr_entry.legal = legal_ff;
               wr_entry.prior = prior_ff;
            end else begin
               wr_entry.win    = (({1'b0, cur.win} + (SUM_W+1)'(winv_ff)) > {1'b0, SUM_MAX})
                                 ? SUM_MAX : cur.win + SUM_W'(winv_ff);
               wr_entry.loss   = (({1'b0, cur.loss} + (SUM_W+1)'(lossv_ff)) > {1'b0, SUM_MAX})
                                 ? SUM_MAX : cur.loss + SUM_W'(lossv_ff);
               wr_entry.visits = (cur.visits == VIS_MAX) ? VIS_MAX : cur.visits + 1'b1;
            end
         end
         ST_QSTART: begin
            div_start = 1'b1;
            if (v_ff == '0) begin
               div_dividend = num_ff;
               div_divisor  = DIVS_W'(v_ff) + 1'b1;
            end else begin
               div_dividend = mag_ff;
               div_divisor  = {1'b0, v_ff};
            end
         end
         ST_QDIV: begin
            div_start    = div_done;
            div_dividend = num_ff;
            div_divisor  = DIVS_W'(v_ff) + 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we)
         mem[action_ff] <= wr_entry;
      rd_entry_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= 16'd4096;
         count_ff     <= 7'(MAX_ACTIONS);
         vld_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= vld_ff[rd_addr];
         if (csr_valid) begin
            unique case (reg_index_type'(csr_index))
               REG_EXPLORE_GAIN: gain_ff  <= csr_data;
               REG_ACTION_COUNT: count_ff <= csr_data[6:0];
               default: ;
            endcase
         end
         if (accept && kind_type'(req_kind) == KIND_CLEAR) begin
            vld_ff   <= '0;
            total_ff <= '0;
         end
         if (mem_we) begin
            vld_ff[action_ff] <= 1'b1;
            if (kind_ff == KIND_BACKUP && total_ff != TOT_MAX)
               total_ff <= total_ff + 1'b1;
         end
         // post a new result when done, else drop the result once taken
         if (state_ff == ST_DONE && rsp_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= kind_type'(req_kind);
         action_ff <= req_action;
         legal_ff  <= req_legal;
         prior_ff  <= req_prior;
         winv_ff   <= req_win_value;
         lossv_ff  <= req_loss_value;
         rad_ff    <= {total_ff, (RAD_W-TOT_W)'(0)};
         rem_ff    <= '0;
         root_ff   <= '0;
         sq_cnt_ff <= '0;
      end
      unique case (state_ff)
         ST_SQRT: begin
            if (total_ff == '0) begin
               root_ff <= ROOT_W'(1);
            end else begin
               // one root bit per cycle from two radicand bits
               if (rem_sh >= trial) begin
                  rem_ff  <= rem_sh - trial;
                  root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
               end else begin
                  rem_ff  <= rem_sh;
                  root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
               end
               rad_ff    <= {rad_ff[RAD_W-3:0], 2'b00};
               sq_cnt_ff <= sq_cnt_ff + 1'b1;
            end
            idx_ff   <= '0;
            found_ff <= 1'b0;
            best_ff  <= '0;
            best_idx_ff <= '0;
         end
         ST_ENTRY: begin
            v_ff   <= cur.visits;
            neg_ff <= diff[SUM_W];
            mag_ff <= diff[SUM_W] ? SUM_W'(-diff) : diff[SUM_W-1:0];
            gp_ff  <= gain_ff * cur.prior;
            if (!cur.legal)
               idx_ff <= idx_ff + 1'b1;
         end
         ST_MUL: begin
            num_ff <= DIVD_W'(prod[2*ROOT_W:28]);
            q_ff   <= '0;
         end
         ST_QDIV: begin
            if (div_done)
               q_ff <= q_new;
         end
         ST_EDIV: begin
            if (div_done) begin
               if (!found_ff || $signed(score) > $signed(best_ff)) begin
                  best_ff     <= score;
                  best_idx_ff <= idx_ff[ACT_W-1:0];
                  found_ff    <= 1'b1;
               end
               idx_ff <= idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_best_ff <= found_ff ? best_idx_ff : '0;
               rsp_none_ff <= !found_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_choice      = rsp_best_ff;
   assign rsp_no_legal    = rsp_none_ff;

endmodule

/* design/pas_checker.sv */
// Port-level checks for puct_action_selector, bound to the top level.
// Depends on pas_pkg for the select code.
module pas_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_kind,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [5:0] rsp_choice,
   input logic       rsp_no_legal
);
   import pas_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_choice)
         && $stable(rsp_no_legal))
      else $error("result changed while stalled");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_legal |-> rsp_choice == '0)
      else $error("no legal action but nonzero index");

   a_select_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == KIND_SELECT |=> req_stall)
      else $error("select did not hold off requests");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind puct_action_selector pas_checker u_pas_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_kind        (req_kind),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_choice      (rsp_choice),
   .rsp_no_legal    (rsp_no_legal)
);
